// ===== rtl/foc_sensor_state_estimator_macros.svh =====
// ----------------------------------------------------------------------------
// foc_sensor_state_estimator_macros.svh
// Assertion macros shared by the estimator checker.
// ----------------------------------------------------------------------------
`ifndef FOC_SENSOR_STATE_ESTIMATOR_MACROS_SVH
`define FOC_SENSOR_STATE_ESTIMATOR_MACROS_SVH

// Same-cycle implication, reset masked
`define FOC_SSE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset masked
`define FOC_SSE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/foc_sse_pkg.sv =====
// ----------------------------------------------------------------------------
// foc_sse_pkg
// Types, constants and arithmetic helpers of the sensor state estimator.
// ----------------------------------------------------------------------------
package foc_sse_pkg;

    // Item opcodes
    localparam logic OP_ANGLE   = 1'b0;
    localparam logic OP_CURRENT = 1'b1;

    // Configuration register indexes
    localparam logic [2:0] CFG_POLE_PAIRS  = 3'd0;
    localparam logic [2:0] CFG_VEL_BW      = 3'd1;
    localparam logic [2:0] CFG_TRACK_GAIN  = 3'd2;
    localparam logic [2:0] CFG_D_SMOOTH    = 3'd3;
    localparam logic [2:0] CFG_Q_SMOOTH    = 3'd4;

    // Clarke constants (Q30)
    localparam logic signed [31:0] K3  = 32'sd357913941;
    localparam logic signed [31:0] KS3 = 32'sd619925131;

    // Quarter-wave sine polynomial coefficients (Q30)
    localparam logic signed [31:0] PC1 = 32'sd1686629713;
    localparam logic signed [31:0] PC3 = 32'sd693598668;
    localparam logic signed [31:0] PC5 = 32'sd85569305;
    localparam logic signed [31:0] PC7 = 32'sd5026995;
    localparam logic signed [31:0] PC9 = 32'sd172272;
    localparam logic signed [63:0] ONE_Q30 = 64'sd1073741824;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_A_ELEC,
        ST_A_TRK,
        ST_A_UPD,
        ST_A_VEL,
        ST_A_SAT,
        ST_C_ALPHA,
        ST_C_BETA,
        ST_S_X,
        ST_S_X2,
        ST_S_SQ,
        ST_S_MUL,
        ST_S_ACC,
        ST_S_LAST,
        ST_S_FIN,
        ST_C_D1,
        ST_C_D2,
        ST_C_D3,
        ST_C_Q1,
        ST_C_Q2,
        ST_C_F1,
        ST_C_F2,
        ST_C_F3,
        ST_C_F4,
        ST_DONE
    } sse_state_t;

    // Arithmetic shift right, rounding toward zero
    function automatic logic signed [63:0] shr_tz(input logic signed [63:0] v,
                                                 input int unsigned sh);
        logic signed [63:0] bias;
        bias = v[63] ? ((64'sd1 <<< sh) - 64'sd1) : 64'sd0;
        return (v + bias) >>> sh;
    endfunction

    // Saturate to signed 16 bits
    function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
        if (v > 64'sd32767)
            return 16'sh7FFF;
        else if (v < -64'sd32768)
            return 16'sh8000;
        else
            return v[15:0];
    endfunction

    // Saturate to signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        else if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        else
            return v[31:0];
    endfunction

    // Horner coefficient after the leading term
    function automatic logic signed [31:0] horner_coef(input logic [1:0] k);
        logic signed [31:0] c;
        case (k)
            2'd0:    c = -PC7;
            2'd1:    c = PC5;
            2'd2:    c = -PC3;
            default: c = PC1;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/foc_sensor_state_estimator.sv =====
// ----------------------------------------------------------------------------
// foc_sensor_state_estimator
// Rotor angle tracking and Clarke/Park current transform for FOC.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): opcode 0 carries rotor_angle, opcode 1
//   carries phase_a/b/c. Every item gives one result on the output channel
//   (out_valid/out_ready) with all held angles, velocity and d/q currents.
//   Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready;
//   write it only while the block is idle.
//   Timing: one shared 34x32 signed multiplier under a sequencer, one
//   product per cycle. An angle item runs the electrical angle, tracker
//   and velocity steps; a current item runs Clarke, two sine evaluations,
//   Park and smoothing. in_ready is low while an item is in work.
//   The result sits in an output register; a new item is accepted while it
//   waits, and the sequencer holds its next result until the slot frees.
//   Reset: registers return to their defaults, tracker unseeded, all held
//   values zero, no result pending.
// ----------------------------------------------------------------------------
module foc_sensor_state_estimator
    import foc_sse_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               opcode,
    input  logic        [15:0] rotor_angle,
    input  logic signed [15:0] phase_a,
    input  logic signed [15:0] phase_b,
    input  logic signed [15:0] phase_c,
    output logic               out_valid,
    input  logic               out_ready,
    output logic        [15:0] electrical_angle,
    output logic        [15:0] mechanical_angle,
    output logic signed [31:0] velocity,
    output logic signed [15:0] id_filtered,
    output logic signed [15:0] iq_filtered,
    output logic signed [15:0] id_raw,
    output logic signed [15:0] iq_raw,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic        [2:0]  cfg_index,
    input  logic        [15:0] cfg_data
);

    sse_state_t state_reg, state_next;

    // Configuration
    logic [5:0]  pole_pairs_reg;
    logic [15:0] vel_bw_reg, track_gain_reg, d_smooth_reg, q_smooth_reg;

    // Held state
    logic               seeded_reg, seeded_next;
    logic        [31:0] tracker_reg, tracker_next;
    logic        [15:0] elec_reg, elec_next, mech_reg, mech_next;
    logic signed [31:0] vel_reg, vel_next;
    logic signed [15:0] dflt_reg, dflt_next, qflt_reg, qflt_next;
    logic signed [15:0] draw_reg, draw_next, qraw_reg, qraw_next;

    // Item operands
    logic        [15:0] ang_reg;
    logic signed [17:0] s1_reg;
    logic signed [16:0] dbc_reg;

    // Work registers
    logic signed [26:0] al_reg, al_next, be_reg, be_next;
    logic signed [31:0] x_reg, x_next, x2_reg, x2_next, p_reg, p_next;
    logic        [1:0]  hk_reg, hk_next, quad_reg, quad_next;
    logic               pass_reg, pass_next;
    logic signed [25:0] sin_reg, sin_next, cos_reg, cos_next;
    logic signed [63:0] acc_reg, acc_next;
    logic signed [63:0] prod_reg;

    // Shared multiplier
    logic signed [33:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [65:0] full_prod;

    // Output slot
    logic               out_valid_reg, out_valid_next, out_load;
    logic        [15:0] o_elec_reg, o_mech_reg;
    logic signed [31:0] o_vel_reg;
    logic signed [15:0] o_dflt_reg, o_qflt_reg, o_draw_reg, o_qraw_reg;

    logic signed [32:0] trk_err;
    logic        [15:0] sang;
    logic        [29:0] xq;
    logic signed [63:0] sv, tmp;
    logic signed [63:0] sum;
    logic signed [63:0] shv;

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign electrical_angle = o_elec_reg;
    assign mechanical_angle = o_mech_reg;
    assign velocity    = o_vel_reg;
    assign id_filtered = o_dflt_reg;
    assign iq_filtered = o_qflt_reg;
    assign id_raw      = o_draw_reg;
    assign iq_raw      = o_qraw_reg;

    assign full_prod = mul_a * mul_b;
    assign trk_err   = $signed({1'b0, ang_reg, 16'h0000}) - $signed({1'b0, tracker_reg});

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pole_pairs_reg <= 6'd7;
            vel_bw_reg     <= 16'd1000;
            track_gain_reg <= 16'd6554;
            d_smooth_reg   <= 16'd32768;
            q_smooth_reg   <= 16'd32768;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_POLE_PAIRS: pole_pairs_reg <= cfg_data[5:0];
                CFG_VEL_BW:     vel_bw_reg     <= cfg_data;
                CFG_TRACK_GAIN: track_gain_reg <= cfg_data;
                CFG_D_SMOOTH:   d_smooth_reg   <= cfg_data;
                CFG_Q_SMOOTH:   q_smooth_reg   <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Control and held state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            seeded_reg    <= 1'b0;
            tracker_reg   <= '0;
            elec_reg      <= '0;
            mech_reg      <= '0;
            vel_reg       <= '0;
            dflt_reg      <= '0;
            qflt_reg      <= '0;
            draw_reg      <= '0;
            qraw_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            seeded_reg    <= seeded_next;
            tracker_reg   <= tracker_next;
            elec_reg      <= elec_next;
            mech_reg      <= mech_next;
            vel_reg       <= vel_next;
            dflt_reg      <= dflt_next;
            qflt_reg      <= qflt_next;
            draw_reg      <= draw_next;
            qraw_reg      <= qraw_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= full_prod[63:0];
        al_reg   <= al_next;
        be_reg   <= be_next;
        x_reg    <= x_next;
        x2_reg   <= x2_next;
        p_reg    <= p_next;
        hk_reg   <= hk_next;
        quad_reg <= quad_next;
        pass_reg <= pass_next;
        sin_reg  <= sin_next;
        cos_reg  <= cos_next;
        acc_reg  <= acc_next;
        if (in_valid && in_ready)
        begin
            ang_reg <= rotor_angle;
            s1_reg  <= 18'(phase_a) + 18'(phase_a) - 18'(phase_b) - 18'(phase_c);
            dbc_reg <= 17'(phase_b) - 17'(phase_c);
        end
        if (out_load)
        begin
            o_elec_reg <= elec_reg;
            o_mech_reg <= mech_reg;
            o_vel_reg  <= vel_reg;
            o_dflt_reg <= dflt_reg;
            o_qflt_reg <= qflt_reg;
            o_draw_reg <= draw_reg;
            o_qraw_reg <= qraw_reg;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        seeded_next    = seeded_reg;
        tracker_next   = tracker_reg;
        elec_next      = elec_reg;
        mech_next      = mech_reg;
        vel_next       = vel_reg;
        dflt_next      = dflt_reg;
        qflt_next      = qflt_reg;
        draw_next      = draw_reg;
        qraw_next      = qraw_reg;
        al_next        = al_reg;
        be_next        = be_reg;
        x_next         = x_reg;
        x2_next        = x2_reg;
        p_next         = p_reg;
        hk_next        = hk_reg;
        quad_next      = quad_reg;
        pass_next      = pass_reg;
        sin_next       = sin_reg;
        cos_next       = cos_reg;
        acc_next       = acc_reg;
        mul_a          = '0;
        mul_b          = '0;
        out_load       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        sang           = pass_reg ? (elec_reg + 16'h4000) : elec_reg;
        xq             = {sang[13:0], 16'h0000};
        sv             = '0;
        tmp            = '0;
        sum            = acc_reg + prod_reg;
        shv            = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = (opcode == OP_CURRENT) ? ST_C_ALPHA : ST_A_ELEC;
            end
            // Electrical angle product; seed tracker on first sample
            ST_A_ELEC:
            begin
                mul_a = 34'($signed({1'b0, ang_reg}));
                mul_b = 32'($signed({1'b0, pole_pairs_reg}));
                if (!seeded_reg)
                begin
                    seeded_next  = 1'b1;
                    tracker_next = {ang_reg, 16'h0000};
                end
                state_next = ST_A_TRK;
            end
            ST_A_TRK:
            begin
                elec_next  = prod_reg[15:0];
                mech_next  = ang_reg;
                mul_a      = 34'(trk_err);
                mul_b      = 32'($signed({1'b0, track_gain_reg}));
                state_next = ST_A_UPD;
            end
            ST_A_UPD:
            begin
                shv          = shr_tz(prod_reg, 16);
                tracker_next = tracker_reg + shv[31:0];
                state_next   = ST_A_VEL;
            end
            ST_A_VEL:
            begin
                mul_a      = 34'(trk_err);
                mul_b      = 32'($signed({1'b0, vel_bw_reg}));
                state_next = ST_A_SAT;
            end
            ST_A_SAT:
            begin
                vel_next   = sat32(shr_tz(prod_reg, 16));
                state_next = ST_DONE;
            end
            // Clarke transform
            ST_C_ALPHA:
            begin
                mul_a      = 34'(s1_reg);
                mul_b      = K3;
                state_next = ST_C_BETA;
            end
            ST_C_BETA:
            begin
                shv        = shr_tz(prod_reg, 22);
                al_next    = shv[26:0];
                mul_a      = 34'(dbc_reg);
                mul_b      = KS3;
                pass_next  = 1'b0;
                state_next = ST_S_X;
            end
            // Sine: quarter-wave reduction (first pass also takes beta)
            ST_S_X:
            begin
                if (!pass_reg)
                begin
                    shv     = shr_tz(prod_reg, 22);
                    be_next = shv[26:0];
                end
                quad_next = sang[15:14];
                if (sang[14])
                    x_next = 32'sd1073741824 - $signed({2'b00, xq});
                else
                    x_next = $signed({2'b00, xq});
                state_next = ST_S_X2;
            end
            ST_S_X2:
            begin
                mul_a      = 34'(x_reg);
                mul_b      = x_reg;
                state_next = ST_S_SQ;
            end
            ST_S_SQ:
            begin
                shv        = prod_reg >>> 30;
                x2_next    = shv[31:0];
                p_next     = PC9;
                hk_next    = 2'd0;
                state_next = ST_S_MUL;
            end
            ST_S_MUL:
            begin
                mul_a      = 34'(p_reg);
                mul_b      = x2_reg;
                state_next = ST_S_ACC;
            end
            ST_S_ACC:
            begin
                shv    = shr_tz(prod_reg, 30);
                p_next = horner_coef(hk_reg) + shv[31:0];
                if (hk_reg == 2'd3)
                    state_next = ST_S_LAST;
                else
                begin
                    hk_next    = hk_reg + 2'd1;
                    state_next = ST_S_MUL;
                end
            end
            ST_S_LAST:
            begin
                mul_a      = 34'(p_reg);
                mul_b      = x_reg;
                state_next = ST_S_FIN;
            end
            // Clamp, apply half-wave sign, scale to Q24
            ST_S_FIN:
            begin
                sv = shr_tz(prod_reg, 30);
                if (sv < 64'sd0)
                    sv = 64'sd0;
                if (sv > ONE_Q30)
                    sv = ONE_Q30;
                if (quad_reg[1])
                    sv = -sv;
                tmp = shr_tz(sv, 6);
                if (pass_reg)
                begin
                    cos_next   = tmp[25:0];
                    state_next = ST_C_D1;
                end
                else
                begin
                    sin_next   = tmp[25:0];
                    pass_next  = 1'b1;
                    state_next = ST_S_X;
                end
            end
            // Park transform
            ST_C_D1:
            begin
                mul_a      = 34'(al_reg);
                mul_b      = 32'(cos_reg);
                state_next = ST_C_D2;
            end
            ST_C_D2:
            begin
                acc_next   = prod_reg;
                mul_a      = 34'(be_reg);
                mul_b      = 32'(sin_reg);
                state_next = ST_C_D3;
            end
            ST_C_D3:
            begin
                draw_next  = sat16(shr_tz(sum, 32));
                mul_a      = 34'(be_reg);
                mul_b      = 32'(cos_reg);
                state_next = ST_C_Q1;
            end
            ST_C_Q1:
            begin
                acc_next   = prod_reg;
                mul_a      = 34'(al_reg);
                mul_b      = 32'(sin_reg);
                state_next = ST_C_Q2;
            end
            ST_C_Q2:
            begin
                qraw_next  = sat16(shr_tz(acc_reg - prod_reg, 32));
                mul_a      = 34'($signed({1'b0, d_smooth_reg}));
                mul_b      = 32'(dflt_reg);
                state_next = ST_C_F1;
            end
            // Complementary smoothing
            ST_C_F1:
            begin
                acc_next   = prod_reg;
                mul_a      = 34'sd65536 - 34'($signed({1'b0, d_smooth_reg}));
                mul_b      = 32'(draw_reg);
                state_next = ST_C_F2;
            end
            ST_C_F2:
            begin
                shv        = shr_tz(sum, 16);
                dflt_next  = shv[15:0];
                mul_a      = 34'($signed({1'b0, q_smooth_reg}));
                mul_b      = 32'(qflt_reg);
                state_next = ST_C_F3;
            end
            ST_C_F3:
            begin
                acc_next   = prod_reg;
                mul_a      = 34'sd65536 - 34'($signed({1'b0, q_smooth_reg}));
                mul_b      = 32'(qraw_reg);
                state_next = ST_C_F4;
            end
            ST_C_F4:
            begin
                shv        = shr_tz(sum, 16);
                qflt_next  = shv[15:0];
                state_next = ST_DONE;
            end
            // Hand the result to the output slot once it is free
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/foc_sse_checker.sv =====
// ----------------------------------------------------------------------------
// foc_sse_props
// Port-level assertions for the sensor state estimator.
// ----------------------------------------------------------------------------
`include "foc_sensor_state_estimator_macros.svh"

module foc_sse_props
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] mechanical_angle,
    input logic        cfg_ready
);

    // Block is busy right after taking an item
    `FOC_SSE_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready, "ready after transfer")

    // A stalled result holds
    `FOC_SSE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(mechanical_angle), "stalled result changed")

    // No result appears in the cycle after an item is taken
    `FOC_SSE_ASSERT_NEXT(a_no_instant, in_valid && in_ready && !out_valid, !out_valid,
        "result too early")

    // Config port never stalls
    `FOC_SSE_ASSERT_NOW(a_cfg_ready, 1'b1, cfg_ready, "config not ready")

endmodule

bind foc_sensor_state_estimator foc_sse_props u_foc_sse_props (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .mechanical_angle (mechanical_angle),
    .cfg_ready        (cfg_ready)
);
